// File: src/kdslp_pkg.sv
// Shared types and constants for the key debounce and press-length detector.
package kdslp_pkg;

  localparam int unsigned ThrWidth = 8;
  localparam logic [ThrWidth-1:0] ThrReset = 8'd70;

  localparam int unsigned PhaseWidth = 2;
  localparam logic [PhaseWidth-1:0] PhIdle     = 2'd0;
  localparam logic [PhaseWidth-1:0] PhDebounce = 2'd1;
  localparam logic [PhaseWidth-1:0] PhHeld     = 2'd2;

  typedef logic [ThrWidth-1:0] thr_t;

  typedef struct packed {
    logic short_flag;
    logic long_flag;
  } lane_flags_t;

endpackage

// File: src/kdslp_lane.sv
// Per-key lane: debounce state machine, saturating hold counter and sticky flags.
module kdslp_lane #(
  parameter int unsigned HOLD_COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  level_i,
  input  logic                  clear_short_i,
  input  logic                  clear_long_i,
  input  kdslp_pkg::thr_t       threshold_i,
  output kdslp_pkg::lane_flags_t flags_o
);
  import kdslp_pkg::*;

  localparam int unsigned CmpWidth =
      (HOLD_COUNT_BITS > ThrWidth) ? HOLD_COUNT_BITS : ThrWidth;
  localparam logic [HOLD_COUNT_BITS-1:0] CountMax = {HOLD_COUNT_BITS{1'b1}};

  logic [PhaseWidth-1:0]      phase_q, phase_d;
  logic [HOLD_COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic                       short_q, short_d, long_q, long_d;
  logic                       pressed, set_short, set_long;
  logic [CmpWidth-1:0]        thr_ext;

  assign pressed   = ~level_i;
  assign thr_ext   = CmpWidth'(threshold_i);
  assign count_inc = (count_q == CountMax) ? count_q
                                           : count_q + HOLD_COUNT_BITS'(1);

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    set_short = 1'b0;
    set_long  = 1'b0;
    case (phase_q)
      PhDebounce: begin
        phase_d = pressed ? PhHeld : PhIdle;
      end
      PhHeld: begin
        if (!pressed) begin
          phase_d   = PhIdle;
          set_short = CmpWidth'(count_q) < thr_ext;
        end else begin
          count_d  = count_inc;
          set_long = CmpWidth'(count_inc) > thr_ext;
        end
      end
      default: begin
        if (pressed) begin
          phase_d = PhDebounce;
          count_d = '0;
        end else begin
          phase_d = PhIdle;
        end
      end
    endcase
    short_d = (short_q & ~clear_short_i) | set_short;
    long_d  = (long_q & ~clear_long_i) | set_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      short_q <= 1'b0;
      long_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  assign flags_o.short_flag = short_d;
  assign flags_o.long_flag  = long_d;

endmodule

// File: src/kdslp_merge.sv
// Merging stage: gathers the lane flags into the registered result beat.
module kdslp_merge #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  kdslp_pkg::lane_flags_t lane_flags_i [NUM_KEYS],
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NUM_KEYS-1:0]    short_flags_o,
  output logic [NUM_KEYS-1:0]    long_flags_o
);
  import kdslp_pkg::*;

  logic                out_valid_q, out_valid_d;
  logic [NUM_KEYS-1:0] short_q, short_d, long_q, long_d;
  logic                load;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign load       = in_valid_i & in_ready_o;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      short_d[k] = lane_flags_i[k].short_flag;
      long_d[k]  = lane_flags_i[k].long_flag;
    end
    out_valid_d = load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign short_flags_o = short_q;
  assign long_flags_o  = long_q;

endmodule

// File: src/key_debounce_short_long_press.sv
// Top level of the key debounce and short/long press detector.
// Each input beat is one scan tick carrying the raw level of every key (low means
// pressed) and per-key clear strobes for the sticky flags; each beat yields exactly
// one result beat with the short and long press flags as they stand after that tick.
// A press is confirmed by two consecutive low samples, held ticks are counted in a
// saturating counter, a long flag is set once the count exceeds the threshold and
// a short flag on release if the count stayed below it. Clear strobes act before the
// tick's own events. Every key has its own lane, so one beat is taken every clock
// cycle unless a result stalls; each result appears registered in the cycle after
// acceptance, and a new beat is taken in the same cycle the waiting one is. The user
// writes the threshold via cfg_we_i and cfg_wdata_i only while idle; the block won't check.
module key_debounce_short_long_press #(
  parameter int unsigned NUM_KEYS        = 4,
  parameter int unsigned HOLD_COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  kdslp_pkg::thr_t       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [NUM_KEYS-1:0]   pin_levels_i,
  input  logic [NUM_KEYS-1:0]   clear_short_i,
  input  logic [NUM_KEYS-1:0]   clear_long_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NUM_KEYS-1:0]   short_flags_o,
  output logic [NUM_KEYS-1:0]   long_flags_o
);
  import kdslp_pkg::*;

  thr_t        threshold_q;
  logic        step;
  lane_flags_t lane_flags [NUM_KEYS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThrReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  assign step = in_valid_i & in_ready_o;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kdslp_lane #(
      .HOLD_COUNT_BITS(HOLD_COUNT_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (step),
      .level_i      (pin_levels_i[k]),
      .clear_short_i(clear_short_i[k]),
      .clear_long_i (clear_long_i[k]),
      .threshold_i  (threshold_q),
      .flags_o      (lane_flags[k])
    );
  end

  kdslp_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .lane_flags_i (lane_flags),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .short_flags_o(short_flags_o),
    .long_flags_o (long_flags_o)
  );

endmodule

// File: src/kdslp_checker.sv
// Port-level assertions for the key debounce detector and their bind to the top level.
module kdslp_checker #(
  parameter int unsigned NUM_KEYS = 4
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [NUM_KEYS-1:0] short_flags_o,
  input logic [NUM_KEYS-1:0] long_flags_o
);

  // A result beat waiting to be taken holds its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(short_flags_o)
      && $stable(long_flags_o))
    else $error("stalled result beat changed");

  // Every accepted tick produces a result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick produced no result beat");

  // No tick is taken while an untaken result would be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result beat stalled");

  // A result beat that was not newly loaded is the old one and so unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) && !$past(in_valid_i && in_ready_o)
      |-> $stable(short_flags_o) && $stable(long_flags_o))
    else $error("flags changed without a new tick");

endmodule

bind key_debounce_short_long_press kdslp_checker #(
  .NUM_KEYS(NUM_KEYS)
) u_kdslp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .short_flags_o(short_flags_o),
  .long_flags_o (long_flags_o)
);
